### design/tqe_pkg.sv
// Shared codes and the controller/datapath command and status structs for the timer engine.
package tqe_pkg;

  localparam int TIME_W = 48;
  localparam int ID_W   = 32;
  localparam int IVL_W  = 32;
  localparam int DIV_CNT_W = 6;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_CANCEL = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;

  localparam logic [2:0] KIND_ADD_OK    = 3'd0;
  localparam logic [2:0] KIND_CANCELED  = 3'd1;
  localparam logic [2:0] KIND_EXPIRED   = 3'd2;
  localparam logic [2:0] KIND_TICK_DONE = 3'd3;
  localparam logic [2:0] KIND_ADD_FULL  = 3'd4;

  typedef struct packed {
    logic       load;
    logic       idx_clr;
    logic       idx_inc;
    logic       add_eval;
    logic       add_write;
    logic       cancel_eval;
    logic       due_eval;
    logic       pick_clr;
    logic       pick_eval;
    logic       pick_take;
    logic       drop;
    logic       div_start;
    logic       rearm_write;
    logic       min_clr;
    logic       min_eval;
    logic       emit;
    logic [2:0] kind;
    logic       with_add_id;
    logic       with_pick_id;
    logic       with_delay;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic add_ok;
    logic pick_found;
    logic slot_due;
    logic slot_periodic;
    logic div_busy;
  } stat_t;

endpackage

### design/tqe_div.sv
// Bit-serial remainder unit: one dividend bit per cycle.
module tqe_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [tqe_pkg::TIME_W-1:0] dividend,
  input  logic [tqe_pkg::IVL_W-1:0]  divisor,
  output logic                     busy,
  output logic [tqe_pkg::IVL_W-1:0]  rem
);
  import tqe_pkg::*;

  logic                 busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [TIME_W-1:0]    dvd_r, dvd_nxt;
  logic [IVL_W-1:0]     dvs_r, dvs_nxt;
  logic [IVL_W-1:0]     rem_r, rem_nxt;
  logic [IVL_W:0]       rem_sh;
  logic [IVL_W:0]       rem_sub;

  always_comb begin
    rem_sh  = {rem_r, dvd_r[TIME_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_r};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(TIME_W - 1);
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[TIME_W-2:0], 1'b0};
      rem_nxt = (rem_sh >= {1'b0, dvs_r}) ? rem_sub[IVL_W-1:0] : rem_sh[IVL_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign busy = busy_r;
  assign rem  = rem_r;

endmodule

### design/tqe_dp.sv
// Timer table datapath: slot memories, scan index, search registers and result register.
module tqe_dp #(
  parameter int SLOTS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tqe_pkg::cmd_t              cmd,
  output tqe_pkg::stat_t             stat,
  input  logic [tqe_pkg::TIME_W-1:0] in_now_ms,
  input  logic [31:0]                in_delay_ms,
  input  logic [tqe_pkg::IVL_W-1:0]  in_interval_ms,
  input  logic [tqe_pkg::ID_W-1:0]   in_cancel_id,
  output logic                       out_valid,
  output logic [2:0]                 out_kind,
  output logic [tqe_pkg::ID_W-1:0]   out_timer_id,
  output logic [tqe_pkg::TIME_W-1:0] out_next_delay_ms,
  output logic                       out_last
);
  import tqe_pkg::*;

  localparam int IW = $clog2(SLOTS);

  logic [TIME_W-1:0] dl_mem [SLOTS];
  logic [IVL_W-1:0]  iv_mem [SLOTS];
  logic [ID_W-1:0]   id_mem [SLOTS];
  logic [TIME_W-1:0] rd_dl_r;
  logic [IVL_W-1:0]  rd_iv_r;
  logic [ID_W-1:0]   rd_id_r;

  logic [SLOTS-1:0]  valid_r, valid_nxt;
  logic [SLOTS-1:0]  due_r, due_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;

  logic [TIME_W-1:0] now_r, dl_r;
  logic [IVL_W-1:0]  ivl_r;
  logic [ID_W-1:0]   cid_r;
  logic [ID_W-1:0]   next_id_r, next_id_nxt;
  logic [ID_W-1:0]   add_id_r, add_id_nxt;

  logic              free_found_r, free_found_nxt;
  logic [IW-1:0]     free_r, free_nxt;
  logic              dup_r, dup_nxt;

  logic              pk_found_r, pk_found_nxt;
  logic [TIME_W-1:0] pk_dl_r, pk_dl_nxt;
  logic [ID_W-1:0]   pk_id_r, pk_id_nxt;
  logic [IW-1:0]     pk_idx_r, pk_idx_nxt;

  logic              min_any_r, min_any_nxt;
  logic [TIME_W-1:0] min_dl_r, min_dl_nxt;

  logic              out_valid_r;
  logic [2:0]        out_kind_r;
  logic [ID_W-1:0]   out_id_r, out_id_nxt;
  logic [TIME_W-1:0] out_delay_r, out_delay_nxt;
  logic              out_last_r;

  logic [TIME_W:0]   add_sum;
  logic [TIME_W-1:0] add_dl;
  logic              slot_v;
  logic              slot_due;
  logic              div_busy;
  logic [IVL_W-1:0]  div_rem;
  logic [TIME_W-1:0] rearm_base;
  logic [TIME_W:0]   rearm_sum;
  logic [TIME_W-1:0] rearm_dl;
  logic [TIME_W-1:0] next_delay;

  assign add_sum = {1'b0, in_now_ms} + {{(TIME_W-31){1'b0}}, in_delay_ms};
  assign add_dl  = add_sum[TIME_W] ? '1 : add_sum[TIME_W-1:0];

  assign slot_v   = valid_r[idx_r];
  assign slot_due = slot_v && (rd_dl_r <= now_r);

  // The new deadline is the old deadline plus the fewest whole intervals that put it past now.
  assign rearm_base = now_r - {{(TIME_W-IVL_W){1'b0}}, div_rem};
  assign rearm_sum  = {1'b0, rearm_base} + {{(TIME_W-IVL_W+1){1'b0}}, rd_iv_r};
  assign rearm_dl   = rearm_sum[TIME_W] ? '1 : rearm_sum[TIME_W-1:0];

  always_comb begin
    if (!min_any_r) begin
      next_delay = '0;
    end else if (min_dl_r <= now_r) begin
      next_delay = TIME_W'(1);
    end else begin
      next_delay = min_dl_r - now_r;
    end
  end

  tqe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (now_r - rd_dl_r),
    .divisor  (rd_iv_r),
    .busy     (div_busy),
    .rem      (div_rem)
  );

  always_comb begin
    idx_nxt        = idx_r;
    valid_nxt      = valid_r;
    due_nxt        = due_r;
    next_id_nxt    = next_id_r;
    add_id_nxt     = add_id_r;
    free_found_nxt = free_found_r;
    free_nxt       = free_r;
    dup_nxt        = dup_r;
    pk_found_nxt   = pk_found_r;
    pk_dl_nxt      = pk_dl_r;
    pk_id_nxt      = pk_id_r;
    pk_idx_nxt     = pk_idx_r;
    min_any_nxt    = min_any_r;
    min_dl_nxt     = min_dl_r;
    out_id_nxt     = '0;
    out_delay_nxt  = '0;

    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + 1'b1;
    end
    if (cmd.load) begin
      free_found_nxt = 1'b0;
      dup_nxt        = 1'b0;
    end
    if (cmd.add_eval) begin
      if (!slot_v && !free_found_r) begin
        free_found_nxt = 1'b1;
        free_nxt       = idx_r;
      end
      if (slot_v && rd_dl_r == dl_r && rd_id_r == next_id_r) begin
        dup_nxt = 1'b1;
      end
    end
    if (cmd.add_write) begin
      if (free_found_r || dup_r) begin
        add_id_nxt  = next_id_r;
        next_id_nxt = next_id_r + 1'b1;
        if (!dup_r) begin
          valid_nxt[free_r] = 1'b1;
        end
      end else begin
        add_id_nxt = '0;
      end
    end
    if (cmd.cancel_eval && slot_v && rd_id_r == cid_r) begin
      valid_nxt[idx_r] = 1'b0;
    end
    if (cmd.due_eval) begin
      due_nxt[idx_r] = slot_due;
    end
    if (cmd.pick_clr) begin
      pk_found_nxt = 1'b0;
    end
    if (cmd.pick_eval && due_r[idx_r]) begin
      if (!pk_found_r || rd_dl_r < pk_dl_r || (rd_dl_r == pk_dl_r && rd_id_r < pk_id_r)) begin
        pk_found_nxt = 1'b1;
        pk_dl_nxt    = rd_dl_r;
        pk_id_nxt    = rd_id_r;
        pk_idx_nxt   = idx_r;
      end
    end
    if (cmd.pick_take) begin
      due_nxt[pk_idx_r] = 1'b0;
    end
    if (cmd.drop) begin
      valid_nxt[idx_r] = 1'b0;
    end
    if (cmd.min_clr) begin
      min_any_nxt = 1'b0;
    end
    if (cmd.min_eval && slot_v && (!min_any_r || rd_dl_r < min_dl_r)) begin
      min_any_nxt = 1'b1;
      min_dl_nxt  = rd_dl_r;
    end
    if (cmd.with_add_id) begin
      out_id_nxt = add_id_r;
    end else if (cmd.with_pick_id) begin
      out_id_nxt = pk_id_r;
    end
    if (cmd.with_delay) begin
      out_delay_nxt = next_delay;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_write && free_found_r && !dup_r) begin
      dl_mem[free_r] <= dl_r;
      iv_mem[free_r] <= ivl_r;
      id_mem[free_r] <= next_id_r;
    end else if (cmd.rearm_write) begin
      dl_mem[idx_r] <= rearm_dl;
    end
    rd_dl_r <= dl_mem[idx_r];
    rd_iv_r <= iv_mem[idx_r];
    rd_id_r <= id_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      next_id_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      next_id_r   <= next_id_nxt;
      out_valid_r <= cmd.emit;
    end
    idx_r        <= idx_nxt;
    due_r        <= due_nxt;
    add_id_r     <= add_id_nxt;
    free_found_r <= free_found_nxt;
    free_r       <= free_nxt;
    dup_r        <= dup_nxt;
    pk_found_r   <= pk_found_nxt;
    pk_dl_r      <= pk_dl_nxt;
    pk_id_r      <= pk_id_nxt;
    pk_idx_r     <= pk_idx_nxt;
    min_any_r    <= min_any_nxt;
    min_dl_r     <= min_dl_nxt;
    if (cmd.load) begin
      now_r <= in_now_ms;
      dl_r  <= add_dl;
      ivl_r <= in_interval_ms;
      cid_r <= in_cancel_id;
    end
    if (cmd.emit) begin
      out_kind_r  <= cmd.kind;
      out_id_r    <= out_id_nxt;
      out_delay_r <= out_delay_nxt;
      out_last_r  <= cmd.last;
    end
  end

  assign stat.idx_last      = (idx_r == IW'(SLOTS - 1));
  assign stat.add_ok        = free_found_r || dup_r;
  assign stat.pick_found    = pk_found_r;
  assign stat.slot_due      = slot_due;
  assign stat.slot_periodic = (rd_iv_r != '0);
  assign stat.div_busy      = div_busy;

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_timer_id      = out_id_r;
  assign out_next_delay_ms = out_delay_r;
  assign out_last          = out_last_r;

endmodule

### design/tqe_ctrl.sv
// Controller state machine that sequences the slot scans of add, cancel and tick.
module tqe_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [1:0]     in_action,
  output logic           busy,
  input  tqe_pkg::stat_t stat,
  output tqe_pkg::cmd_t  cmd
);
  import tqe_pkg::*;

  typedef enum logic [18:0] {
    S_IDLE = 19'h00001,
    S_A_RD = 19'h00002,
    S_A_EV = 19'h00004,
    S_A_WR = 19'h00008,
    S_C_RD = 19'h00010,
    S_C_EV = 19'h00020,
    S_C_OUT = 19'h00040,
    S_T_RD = 19'h00080,
    S_T_EV = 19'h00100,
    S_P_RD = 19'h00200,
    S_P_EV = 19'h00400,
    S_P_CHK = 19'h00800,
    S_R_RD = 19'h01000,
    S_R_EV = 19'h02000,
    S_R_DIV = 19'h04000,
    S_R_WR = 19'h08000,
    S_M_RD = 19'h10000,
    S_M_EV = 19'h20000,
    S_M_OUT = 19'h40000
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] kind_r, kind_nxt;

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load    = 1'b1;
          cmd.idx_clr = 1'b1;
          case (in_action)
            ACT_ADD:    state_nxt = S_A_RD;
            ACT_CANCEL: state_nxt = S_C_RD;
            ACT_TICK:   state_nxt = S_T_RD;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_A_RD: state_nxt = S_A_EV;
      S_A_EV: begin
        cmd.add_eval = 1'b1;
        if (stat.idx_last) begin
          state_nxt = S_A_WR;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_A_RD;
        end
      end
      S_A_WR: begin
        cmd.add_write = 1'b1;
        cmd.idx_clr   = 1'b1;
        cmd.min_clr   = 1'b1;
        kind_nxt      = stat.add_ok ? KIND_ADD_OK : KIND_ADD_FULL;
        state_nxt     = S_M_RD;
      end
      S_C_RD: state_nxt = S_C_EV;
      S_C_EV: begin
        cmd.cancel_eval = 1'b1;
        if (stat.idx_last) begin
          state_nxt = S_C_OUT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_C_RD;
        end
      end
      S_C_OUT: begin
        cmd.emit  = 1'b1;
        cmd.kind  = KIND_CANCELED;
        cmd.last  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_T_RD: state_nxt = S_T_EV;
      S_T_EV: begin
        cmd.due_eval = 1'b1;
        if (stat.idx_last) begin
          cmd.idx_clr  = 1'b1;
          cmd.pick_clr = 1'b1;
          state_nxt    = S_P_RD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_T_RD;
        end
      end
      S_P_RD: state_nxt = S_P_EV;
      S_P_EV: begin
        cmd.pick_eval = 1'b1;
        if (stat.idx_last) begin
          state_nxt = S_P_CHK;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_P_RD;
        end
      end
      S_P_CHK: begin
        cmd.idx_clr = 1'b1;
        if (stat.pick_found) begin
          cmd.pick_take    = 1'b1;
          cmd.pick_clr     = 1'b1;
          cmd.emit         = 1'b1;
          cmd.kind         = KIND_EXPIRED;
          cmd.with_pick_id = 1'b1;
          state_nxt        = S_P_RD;
        end else begin
          state_nxt = S_R_RD;
        end
      end
      S_R_RD: state_nxt = S_R_EV;
      S_R_EV: begin
        if (stat.slot_due && stat.slot_periodic) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_R_DIV;
        end else begin
          cmd.drop = stat.slot_due;
          if (stat.idx_last) begin
            cmd.idx_clr = 1'b1;
            cmd.min_clr = 1'b1;
            kind_nxt    = KIND_TICK_DONE;
            state_nxt   = S_M_RD;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_R_RD;
          end
        end
      end
      S_R_DIV: begin
        if (!stat.div_busy) begin
          state_nxt = S_R_WR;
        end
      end
      S_R_WR: begin
        cmd.rearm_write = 1'b1;
        if (stat.idx_last) begin
          cmd.idx_clr = 1'b1;
          cmd.min_clr = 1'b1;
          kind_nxt    = KIND_TICK_DONE;
          state_nxt   = S_M_RD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_R_RD;
        end
      end
      S_M_RD: state_nxt = S_M_EV;
      S_M_EV: begin
        cmd.min_eval = 1'b1;
        if (stat.idx_last) begin
          state_nxt = S_M_OUT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_M_RD;
        end
      end
      S_M_OUT: begin
        cmd.emit        = 1'b1;
        cmd.kind        = kind_r;
        cmd.with_add_id = (kind_r == KIND_ADD_OK);
        cmd.with_delay  = 1'b1;
        cmd.last        = 1'b1;
        state_nxt       = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    kind_r <= kind_nxt;
  end

  assign busy = (state_r != S_IDLE);

endmodule

### design/timer_queue_expiry_engine.sv
// Top level of the timer queue expiry engine.
// A word is taken when start is high and busy is low; results appear one per
// strobe on out_valid and must be taken in that cycle, since the receiver cannot
// stall. Every operation walks all SLOTS entries through one registered memory
// read port, with a read state and an evaluate state per slot. Add scans for a
// free slot and then for the next delay; cancel scans once. A tick makes the due
// scan, one search per expired timer plus one more empty search, a re-arm scan
// that re-arms due periodic timers via the serial remainder unit and drops due
// one-shots, and the final next-delay search. Reset empties the table at once.
module timer_queue_expiry_engine #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [47:0] in_now_ms,
  input  logic [31:0] in_delay_ms,
  input  logic [31:0] in_interval_ms,
  input  logic [31:0] in_cancel_id,
  output logic        out_valid,
  output logic [2:0]  out_kind,
  output logic [31:0] out_timer_id,
  output logic [47:0] out_next_delay_ms,
  output logic        out_last
);
  import tqe_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  tqe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .busy      (busy),
    .stat      (stat),
    .cmd       (cmd)
  );

  tqe_dp #(.SLOTS(SLOTS)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_now_ms         (in_now_ms),
    .in_delay_ms       (in_delay_ms),
    .in_interval_ms    (in_interval_ms),
    .in_cancel_id      (in_cancel_id),
    .out_valid         (out_valid),
    .out_kind          (out_kind),
    .out_timer_id      (out_timer_id),
    .out_next_delay_ms (out_next_delay_ms),
    .out_last          (out_last)
  );

  // No result can appear in the cycle right after a word is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> !out_valid)
    else $error("result too soon after accept");

  // The final result of a word is followed by a quiet cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("result after final result");

  // While idle, only the final result of the previous word can be showing.
  assert property (@(posedge clk) disable iff (!rst_n)
    !busy && out_valid |-> out_last)
    else $error("partial result while idle");

  // Expiry results never close a tick.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_EXPIRED |-> !out_last && out_next_delay_ms == '0)
    else $error("malformed expiry result");

endmodule
